>>> hw/rtl/ppcb_pkg.sv
package ppcb_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RAW   = 2'd1,
    REQ_HEAD  = 2'd2,
    REQ_END   = 2'd3
  } req_e;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegFrameLimit = 3'd0;

  localparam logic [15:0] FrameLimitRst = 16'd1024;
  localparam logic [15:0] FcsInit       = 16'hFFFF;
  localparam logic [15:0] FcsPoly       = 16'h8408;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  localparam logic [4:0] AddlU8  = 5'd24;
  localparam logic [4:0] AddlU16 = 5'd25;
  localparam logic [4:0] AddlU32 = 5'd26;
  localparam logic [4:0] AddlU64 = 5'd27;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FcsPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ppcb_regs.sv
module ppcb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppcb_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [15:0]                     frame_limit_o
);
  import ppcb_pkg::*;

  logic [15:0] frame_limit_q;
  logic        hit;

  assign hit    = (paddr[CfgAddrW-1:2] == RegFrameLimit[CfgAddrW-1:2]);
  assign pready = 1'b1;
  assign prdata = hit ? {16'h0000, frame_limit_q} : 32'h0000_0000;
  assign frame_limit_o = frame_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= FrameLimitRst;
    end else if (psel && penable && pwrite && hit) begin
      frame_limit_q <= pwdata[15:0];
    end
  end

endmodule

>>> hw/rtl/ppcb_seq.sv
module ppcb_seq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [15:0]  frame_limit_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   req_type_i,
  input  logic [7:0]   data_byte_i,
  input  logic [2:0]   major_type_i,
  input  logic [63:0]  head_value_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         last_o,
  output logic         dropped_o
);
  import ppcb_pkg::*;

  logic        work_valid_q;
  req_e        type_q;
  logic [7:0]  data_q;
  logic [7:0]  init_q;
  logic [63:0] hv_q;
  logic [3:0]  cnt_q;
  logic [3:0]  k_q;
  logic        esc_q;
  logic [7:0]  hi_q;
  logic [15:0] fcs_q;
  logic [15:0] count_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        last_q;
  logic        dropped_q;

  req_e        in_type;
  logic [7:0]  init_d;
  logic [3:0]  cnt_d;
  logic        load;
  logic        adv;
  logic [7:0]  src;
  logic        flag;
  logic        needs_esc;
  logic        step_done;
  logic        item_done;
  logic [7:0]  line_byte;
  logic [3:0]  sel;
  logic [15:0] base;
  logic        fits;

  assign in_type = req_e'(req_type_i);

  always_comb begin
    init_d = data_byte_i;
    cnt_d  = 4'd1;
    case (in_type)
      REQ_HEAD: begin
        if (head_value_i < 64'd24) begin
          init_d = {major_type_i, head_value_i[4:0]};
          cnt_d  = 4'd1;
        end else if (head_value_i < 64'd256) begin
          init_d = {major_type_i, AddlU8};
          cnt_d  = 4'd2;
        end else if (head_value_i < 64'd65536) begin
          init_d = {major_type_i, AddlU16};
          cnt_d  = 4'd3;
        end else if (head_value_i < 64'd4294967296) begin
          init_d = {major_type_i, AddlU32};
          cnt_d  = 4'd5;
        end else begin
          init_d = {major_type_i, AddlU64};
          cnt_d  = 4'd9;
        end
      end
      REQ_END: cnt_d = 4'd3;
      default: cnt_d = 4'd1;
    endcase
  end

  assign sel = cnt_q - 4'd1 - k_q;

  always_comb begin
    src  = init_q;
    flag = 1'b0;
    case (type_q)
      REQ_START: begin
        src  = FlagByte;
        flag = 1'b1;
      end
      REQ_RAW:  src = data_q;
      REQ_HEAD: src = (k_q == 4'd0) ? init_q : hv_q[{sel[2:0], 3'b000} +: 8];
      REQ_END: begin
        if (k_q == 4'd0) begin
          src = ~fcs_q[7:0];
        end else if (k_q == 4'd1) begin
          src = hi_q;
        end else begin
          src  = FlagByte;
          flag = 1'b1;
        end
      end
      default: src = init_q;
    endcase
  end

  assign needs_esc = !flag && ((src == FlagByte) || (src == EscByte));
  assign step_done = !needs_esc || esc_q;
  assign item_done = step_done && (k_q == cnt_q - 4'd1);
  assign line_byte = esc_q ? (src ^ EscXor) : (needs_esc ? EscByte : src);

  assign adv        = work_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = work_valid_q && !(adv && item_done);
  assign load       = in_valid_i && !in_stall_o;

  assign base = (type_q == REQ_START) ? 16'h0000 : count_q;
  assign fits = ({1'b0, base} + 17'd1) <= {1'b0, frame_limit_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      type_q       <= REQ_START;
      k_q          <= 4'd0;
      cnt_q        <= 4'd1;
      esc_q        <= 1'b0;
      fcs_q        <= FcsInit;
      count_q      <= 16'h0000;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        if (type_q == REQ_START) begin
          fcs_q <= FcsInit;
        end else if (!flag && step_done) begin
          fcs_q <= fcs_update(fcs_q, src);
        end
        count_q <= fits ? (base + 16'd1) : base;
      end
      if (load) begin
        work_valid_q <= 1'b1;
        type_q       <= in_type;
        cnt_q        <= cnt_d;
        k_q          <= 4'd0;
        esc_q        <= 1'b0;
      end else if (adv) begin
        if (step_done) begin
          esc_q <= 1'b0;
          k_q   <= k_q + 4'd1;
        end else begin
          esc_q <= 1'b1;
        end
        if (item_done) begin
          work_valid_q <= 1'b0;
        end
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= work_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_byte_i;
      init_q <= init_d;
      hv_q   <= head_value_i;
    end
    if (adv && (type_q == REQ_END) && (k_q == 4'd0) && !esc_q) begin
      hi_q <= ~fcs_q[15:8];
    end
    if (adv) begin
      out_byte_q <= line_byte;
      last_q     <= item_done;
      dropped_q  <= !fits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign dropped_o   = dropped_q;

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q |-> (k_q < cnt_q))
    else $error("byte index past item length");

  a_esc_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work_valid_q && esc_q) |-> (!flag && ((src == FlagByte) || (src == EscByte))))
    else $error("escape second half without escapable byte");

  a_load_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && work_valid_q) |-> (adv && item_done))
    else $error("new request loaded over unfinished item");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("emitted byte lost");

endmodule

>>> hw/rtl/ppp_cbor_frame_encoder_top.sv
// Channel   Valid        Stall         Payload
// request   in_valid_i   in_stall_o    req_type_i, data_byte_i, major_type_i, head_value_i
// line      out_valid_o  out_stall_i   out_byte_o, last_o, dropped_o
// config    APB          pready = 1    paddr, pwdata, prdata (frame_limit at 0x0)
//
// One line byte per cycle while the line does not stall; bytes emitted per request:
// start 1, raw 1-2, head 1-17, end 3-5. The byte sequencer sets these counts.
// The next request is taken in the cycle its predecessor emits its final byte.
// Reset sets FCS to 0xFFFF, byte count to 0 and frame_limit to 1024.
// A stalled line holds the output register and the sequencer.
module ppp_cbor_frame_encoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppcb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [2:0]                     major_type_i,
  input  logic [63:0]                    head_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_o,
  output logic                           dropped_o
);
  import ppcb_pkg::*;

  logic [15:0] frame_limit;

  ppcb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_limit_o (frame_limit)
  );

  ppcb_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_limit_i (frame_limit),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .major_type_i  (major_type_i),
    .head_value_i  (head_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .dropped_o     (dropped_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ppcb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       dropped;
  } line_byte_t;

  localparam int unsigned CycleLimit = 1_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          req_type_i;
  logic [7:0]          data_byte_i;
  logic [2:0]          major_type_i;
  logic [63:0]         head_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          out_byte_o;
  logic                last_o;
  logic                dropped_o;

  line_byte_t  line_bytes_q[$];
  logic [15:0] enc_limit;
  logic [15:0] enc_fcs;
  logic [15:0] enc_count;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned long_hold_cycles = 0;
  bit          gaps_enabled = 1'b1;

  ppp_cbor_frame_encoder_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Line byte prediction

  function automatic logic [15:0] fcs16_fold(logic [15:0] fcs, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = fcs;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ FcsPoly;
      end
    end
    return c;
  endfunction

  function automatic void push_line(logic [7:0] b);
    line_byte_t lb;
    lb.value   = b;
    lb.last    = 1'b0;
    lb.dropped = ({1'b0, enc_count} + 17'd1) > {1'b0, enc_limit};
    if (!lb.dropped) begin
      enc_count = enc_count + 16'd1;
    end
    line_bytes_q.insert(line_bytes_q.size(), lb);
  endfunction

  function automatic void push_escaped(logic [7:0] b);
    enc_fcs = fcs16_fold(enc_fcs, b);
    if (b == EscByte || b == FlagByte) begin
      push_line(EscByte);
      push_line(b ^ EscXor);
    end else begin
      push_line(b);
    end
  endfunction

  function automatic void push_head(logic [2:0] mt, logic [63:0] hv);
    logic [4:0] addl;
    int         nbytes;
    if (hv < 64'd24) begin
      push_escaped({mt, hv[4:0]});
    end else begin
      if (hv < 64'd256) begin
        addl   = AddlU8;
        nbytes = 1;
      end else if (hv < 64'd65536) begin
        addl   = AddlU16;
        nbytes = 2;
      end else if (hv < 64'h1_0000_0000) begin
        addl   = AddlU32;
        nbytes = 4;
      end else begin
        addl   = AddlU64;
        nbytes = 8;
      end
      push_escaped({mt, addl});
      for (int i = nbytes - 1; i >= 0; i--) begin
        push_escaped(hv[8*i +: 8]);
      end
    end
  endfunction

  function automatic void encode_request(req_e req, logic [7:0] data, logic [2:0] mt,
                                         logic [63:0] hv);
    logic [15:0] fcs_out;
    case (req)
      REQ_START: begin
        enc_fcs   = FcsInit;
        enc_count = '0;
        push_line(FlagByte);
      end
      REQ_RAW: begin
        push_escaped(data);
      end
      REQ_HEAD: begin
        push_head(mt, hv);
      end
      default: begin
        fcs_out = ~enc_fcs;
        push_escaped(fcs_out[7:0]);
        push_escaped(fcs_out[15:8]);
        push_line(FlagByte);
      end
    endcase
    line_bytes_q[line_bytes_q.size() - 1].last = 1'b1;
  endfunction

  // Line byte checking

  always @(posedge clk_i) begin
    line_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_bytes_q.size() == 0) begin
        $error("line byte %02h with no request pending", out_byte_o);
        fail_count++;
      end else begin
        exp_b = line_bytes_q.pop_front();
        if (out_byte_o !== exp_b.value) begin
          $error("out_byte: expected %02h, actual %02h", exp_b.value, out_byte_o);
          fail_count++;
        end
        if (last_o !== exp_b.last) begin
          $error("last: expected %0b, actual %0b", exp_b.last, last_o);
          fail_count++;
        end
        if (dropped_o !== exp_b.dropped) begin
          $error("dropped: expected %0b, actual %0b", exp_b.dropped, dropped_o);
          fail_count++;
        end
      end
    end
  end

  // Line stall

  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_mode;
    int unsigned r;
    hold_left   = 0;
    mode_left   = 0;
    stall_mode  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 200);
      end else begin
        mode_left--;
      end
      if (long_hold_cycles != 0) begin
        hold_left        = long_hold_cycles;
        long_hold_cycles = 0;
      end
      r = $urandom_range(0, 99);
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_mode == 0) begin
        out_stall_i = 1'b0;
      end else if (r < 2) begin
        hold_left   = $urandom_range(8, 25);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = (r < ((stall_mode == 1) ? 20 : 50));
      end
    end
  end

  // Request side

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(req_e req, logic [7:0] data, logic [2:0] mt, logic [63:0] hv);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    req_type_i   = req;
    data_byte_i  = data;
    major_type_i = mt;
    head_value_i = hv;
    do @(posedge clk_i); while (in_stall_o);
    encode_request(req, data, mt, hv);
    requests_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_start();
    send_request(REQ_START, 8'($urandom), 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_raw(logic [7:0] b);
    send_request(REQ_RAW, b, 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_head(logic [2:0] mt, logic [63:0] hv);
    send_request(REQ_HEAD, 8'($urandom), mt, hv);
  endtask

  task automatic send_end();
    send_request(REQ_END, 8'($urandom), 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic drain_line();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (line_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_frame_limit(logic [15:0] limit);
    drain_line();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = RegFrameLimit;
    pwdata  = {16'h0000, limit};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    enc_limit = limit;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== limit) begin
      $error("frame_limit: expected %04h, actual %04h", limit, prdata[15:0]);
      fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [7:0] rand_raw_byte();
    case ($urandom_range(0, 7))
      0: return FlagByte;
      1: return EscByte;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_head_value();
    logic [63:0] v;
    int unsigned nbytes;
    int unsigned k;
    case ($urandom_range(0, 4))
      0: begin
        v      = 64'($urandom_range(0, 23));
        nbytes = 0;
      end
      1: begin
        v      = 64'($urandom_range(24, 255));
        nbytes = 1;
      end
      2: begin
        v      = 64'($urandom_range(256, 65535));
        nbytes = 2;
      end
      3: begin
        v      = 64'($urandom_range(65536, 32'hFFFF_FFFF));
        nbytes = 4;
      end
      default: begin
        v      = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
        nbytes = 8;
      end
    endcase
    if (nbytes != 0 && $urandom_range(0, 2) == 0) begin
      k = $urandom_range(0, nbytes - 1);
      v[8*k +: 8] = $urandom_range(0, 1) ? FlagByte : EscByte;
    end
    return v;
  endfunction

  task automatic send_body_item();
    if ($urandom_range(0, 1) == 0) begin
      send_raw(rand_raw_byte());
    end else begin
      send_head(3'($urandom), rand_head_value());
    end
  endtask

  task automatic send_noise_item();
    send_request(req_e'($urandom_range(0, 3)), 8'($urandom), 3'($urandom), rand_head_value());
  endtask

  task automatic send_random_frame();
    int unsigned body_len;
    body_len = $urandom_range(0, 8);
    if ($urandom_range(0, 19) != 0) begin
      send_start();
    end
    repeat (body_len) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise_item();
      end else begin
        send_body_item();
      end
    end
    if ($urandom_range(0, 19) != 0) begin
      send_end();
    end
  endtask

  // Tests

  task automatic test_directed_requests();
    send_raw(8'hA5);
    send_end();
    send_start();
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(FlagByte);
    send_raw(EscByte);
    send_head(3'd0, 64'd0);
    send_head(3'd1, 64'd23);
    send_head(3'd2, 64'd24);
    send_head(3'd3, 64'd255);
    send_head(3'd4, 64'd256);
    send_head(3'd5, 64'd65535);
    send_head(3'd6, 64'd65536);
    send_head(3'd7, 64'hFFFF_FFFF);
    send_head(3'd2, 64'h1_0000_0000);
    send_head(3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_head(3'd3, 64'h7E7D_7E7D_7E7D_7E7D);
    send_end();
    send_start();
    send_end();
  endtask

  task automatic test_frame_limits();
    write_frame_limit(16'd1);
    send_start();
    send_raw(8'h11);
    send_end();
    write_frame_limit(16'd0);
    send_start();
    send_raw(FlagByte);
    send_end();
    write_frame_limit(16'd6);
    send_start();
    send_raw(EscByte);
    send_head(3'd1, 64'h7E00);
    send_end();
  endtask

  task automatic test_random_frames();
    int unsigned target;
    logic [15:0] limit;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: limit = 16'($urandom_range(1, 12));
        1: limit = 16'($urandom_range(13, 60));
        2: limit = (phase < 4) ? FrameLimitRst : 16'hFFFF;
        default: limit = 16'($urandom_range(1, 65535));
      endcase
      write_frame_limit(limit);
      gaps_enabled = (phase != 5);
      target = requests_sent + 35;
      while (requests_sent < target) begin
        send_random_frame();
      end
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int unsigned target;
    write_frame_limit(FrameLimitRst);
    gaps_enabled     = 1'b0;
    long_hold_cycles = 300;
    target           = requests_sent + 40;
    while (requests_sent < target) begin
      send_random_frame();
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_pause_and_resume();
    repeat (3) begin
      send_random_frame();
      drain_line();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_START;
    data_byte_i  = '0;
    major_type_i = '0;
    head_value_i = '0;
    enc_limit    = FrameLimitRst;
    enc_fcs      = FcsInit;
    enc_count    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_requests();
    test_frame_limits();
    test_random_frames();
    test_output_backpressure();
    test_pause_and_resume();

    drain_line();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
